@@ src/snis_pkg.sv @@
// shared constants and codes for the sorted node insert and search block
package snis_pkg;

    // node geometry default
    localparam int KEY_SLOTS_DEF = 256;

    // fixed field widths
    localparam int KEY_W     = 32;
    localparam int PTR_W     = 32;
    localparam int POS_W     = 9;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF     = 1'd1;

    // configuration reset values
    localparam logic [CFG_DAT_W-1:0] CAPACITY_RESET = 9'd127;

endpackage

@@ src/sorted_node_insert_search.sv @@
// search: a binary search, each halving step a probe read then a signed compare
// insert: one key, and in internal mode one child, moved per cycle, from the last key down to position
// clear, refused insert and unused request skip the search and the shift; one item in flight at a time
// the single read and write port of each node memory paces every step
// reset clears the state machine, key count and configuration; node memories are not cleared
// a finished result waits in the output register while the next item is taken
module sorted_node_insert_search
    import snis_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [REQ_W-1:0]            req_type,
    input  logic signed [KEY_W-1:0]     key,
    input  logic [POS_W-1:0]            position,
    input  logic signed [PTR_W-1:0]     child_ptr,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [POS_W-1:0]            index,
    output logic signed [PTR_W-1:0]     child_out,
    output logic [STATUS_W-1:0]         status,
    output logic [POS_W-1:0]            key_count
);

    // count and address widths
    localparam int CW  = $clog2(KEY_SLOTS + 1);
    localparam int KAW = $clog2(KEY_SLOTS);
    localparam int SW  = CW + 1;
    localparam int WW  = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(KEY_SLOTS);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_CHILD_RD = 9'b000001000,
        S_CHILD_CAP= 9'b000010000,
        S_SHIFT    = 9'b000100000,
        S_PLACE    = 9'b001000000,
        S_CLEAR    = 9'b010000000,
        S_FINISH   = 9'b100000000
    } state_t;

    // control registers
    state_t                 state_reg, state_next;
    logic [CW-1:0]          key_total_reg, key_total_next;
    logic [CFG_DAT_W-1:0]   capacity_reg, capacity_next;
    logic                   leaf_reg, leaf_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath registers
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [KAW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]          s_reg, s_next;
    logic [CW-1:0]          wa_reg, wa_next;
    logic [CW-1:0]          cidx_reg, cidx_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_in_reg, key_in_next;
    logic [PTR_W-1:0]       cptr_reg, cptr_next;
    logic                   res_found_reg, res_found_next;
    logic [POS_W-1:0]       res_idx_reg, res_idx_next;
    logic [PTR_W-1:0]       res_child_reg, res_child_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   found_reg, found_next;
    logic [POS_W-1:0]       index_reg, index_next;
    logic [PTR_W-1:0]       child_out_reg, child_out_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [POS_W-1:0]       key_count_reg, key_count_next;

    // node memories
    logic [KEY_W-1:0]       key_mem [KEY_SLOTS];
    logic [PTR_W-1:0]       child_mem [KEY_SLOTS+1];
    logic [KEY_W-1:0]       key_rd_data_reg;
    logic [PTR_W-1:0]       child_rd_data_reg;

    // memory port controls
    logic [KAW-1:0]         key_rd_addr, key_wa;
    logic [KEY_W-1:0]       key_wd;
    logic                   key_we;
    logic [CW-1:0]          child_rd_addr, child_wa;
    logic [PTR_W-1:0]       child_wd;
    logic                   child_we;

    // search and insert helpers
    logic [SW-1:0]          mid_sum;
    logic [KAW-1:0]         mid_calc;
    logic [CW-1:0]          hit_idx;
    logic                   node_full;

    assign mid_sum   = SW'(lo_reg) + SW'(hi_reg) - SW'(1);
    assign mid_calc  = KAW'(mid_sum >> 1);
    assign hit_idx   = CW'(mid_reg) + CW'(!leaf_reg);
    assign node_full = (WW'(key_total_reg) >= WW'(capacity_reg)) || (key_total_reg >= SLOTS_C);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign index     = index_reg;
    assign child_out = child_out_reg;
    assign status    = status_reg;
    assign key_count = key_count_reg;

    // sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        key_total_next  = key_total_reg;
        capacity_next   = capacity_reg;
        leaf_next       = leaf_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        s_next          = s_reg;
        wa_next         = wa_reg;
        cidx_next       = cidx_reg;
        pos_next        = pos_reg;
        key_in_next     = key_in_reg;
        cptr_next       = cptr_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        res_child_next  = res_child_reg;
        res_status_next = res_status_reg;
        found_next      = found_reg;
        index_next      = index_reg;
        child_out_next  = child_out_reg;
        status_next     = status_reg;
        key_count_next  = key_count_reg;
        key_rd_addr     = '0;
        key_we          = 1'b0;
        key_wa          = '0;
        key_wd          = '0;
        child_rd_addr   = '0;
        child_we        = 1'b0;
        child_wa        = '0;
        child_wd        = '0;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAPACITY: capacity_next = cfg_data;
                CFG_LEAF:     leaf_next = cfg_data[0];
                default:      ;
            endcase
        end

        // result transfer frees the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_in_next     = key;
                    pos_next        = position;
                    cptr_next       = child_ptr;
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_child_next  = '0;
                    res_status_next = ST_OK;
                    case (req_type)
                        REQ_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = key_total_reg;
                            state_next = S_SRCH_RD;
                        end
                        REQ_INSERT:
                        begin
                            res_idx_next = position;
                            if (node_full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else if (WW'(position) > WW'(key_total_reg))
                            begin
                                res_status_next = ST_BAD_POS;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                s_next     = key_total_reg;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // issue one probe read or end the search on a miss
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    key_rd_addr = mid_calc;
                    mid_next    = mid_calc;
                    state_next  = S_SRCH_CMP;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = POS_W'(lo_reg);
                    cidx_next      = lo_reg;
                    state_next     = S_CHILD_RD;
                end
            end

            // signed compare against the probed key
            S_SRCH_CMP:
            begin
                if (key_in_reg == $signed(key_rd_data_reg))
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = POS_W'(hit_idx);
                    cidx_next      = hit_idx;
                    state_next     = S_CHILD_RD;
                end
                else if (key_in_reg < $signed(key_rd_data_reg))
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = S_SRCH_RD;
                end
            end

            // child lookup only in internal mode
            S_CHILD_RD:
            begin
                if (leaf_reg)
                begin
                    res_child_next = '0;
                    state_next     = S_FINISH;
                end
                else
                begin
                    child_rd_addr = cidx_reg;
                    state_next    = S_CHILD_CAP;
                end
            end

            S_CHILD_CAP:
            begin
                res_child_next = child_rd_data_reg;
                state_next     = S_FINISH;
            end

            // overlapped shift: write the entry read last cycle, read the next one down
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    key_we   = 1'b1;
                    key_wa   = KAW'(wa_reg);
                    key_wd   = key_rd_data_reg;
                    child_we = !leaf_reg;
                    child_wa = wa_reg + CW'(1);
                    child_wd = child_rd_data_reg;
                end
                if (WW'(s_reg) > WW'(pos_reg))
                begin
                    key_rd_addr   = KAW'(s_reg - CW'(1));
                    child_rd_addr = s_reg;
                    wa_next       = s_reg;
                    s_next        = s_reg - CW'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PLACE;
                end
            end

            // place new key and its right child
            S_PLACE:
            begin
                key_we         = 1'b1;
                key_wa         = KAW'(pos_reg);
                key_wd         = key_in_reg;
                child_we       = !leaf_reg;
                child_wa       = CW'(pos_reg) + CW'(1);
                child_wd       = cptr_reg;
                key_total_next = key_total_reg + CW'(1);
                state_next     = S_FINISH;
            end

            // empty the node and set the leftmost child
            S_CLEAR:
            begin
                child_we       = 1'b1;
                child_wa       = '0;
                child_wd       = cptr_reg;
                key_total_next = '0;
                state_next     = S_FINISH;
            end

            // load the output register once it is free
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    index_next     = res_idx_reg;
                    child_out_next = res_child_reg;
                    status_next    = res_status_reg;
                    key_count_next = POS_W'(key_total_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_total_reg <= '0;
            capacity_reg  <= CAPACITY_RESET;
            leaf_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_total_reg <= key_total_next;
            capacity_reg  <= capacity_next;
            leaf_reg      <= leaf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        s_reg          <= s_next;
        wa_reg         <= wa_next;
        cidx_reg       <= cidx_next;
        pos_reg        <= pos_next;
        key_in_reg     <= key_in_next;
        cptr_reg       <= cptr_next;
        res_found_reg  <= res_found_next;
        res_idx_reg    <= res_idx_next;
        res_child_reg  <= res_child_next;
        res_status_reg <= res_status_next;
        found_reg      <= found_next;
        index_reg      <= index_next;
        child_out_reg  <= child_out_next;
        status_reg     <= status_next;
        key_count_reg  <= key_count_next;
    end

    // key memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd_data_reg <= key_mem[key_rd_addr];
    end

    // child memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_wa] <= child_wd;
        end
        child_rd_data_reg <= child_mem[child_rd_addr];
    end

endmodule

@@ src/snis_checker.sv @@
// port-level checks for the sorted node insert and search block, with its bind
module snis_checker
    import snis_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        found,
    input  logic [POS_W-1:0]            index,
    input  logic signed [PTR_W-1:0]     child_out,
    input  logic [STATUS_W-1:0]         status,
    input  logic [POS_W-1:0]            key_count
);

    // a hit only comes from a search, which never reports a refusal
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_OK)
        else $error("hit reported with a refusal status");

    // a refused insert carries no hit and no child
    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !found && child_out == 0)
        else $error("refused insert carries search fields");

    // the node never reports more keys than it has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(key_count) <= KEY_SLOTS)
        else $error("key count beyond node size");

    // one item in flight: no request taken right after a transfer in
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while an item is at work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(index) && $stable(key_count))
        else $error("stalled result changed");

endmodule

bind sorted_node_insert_search snis_checker #(.KEY_SLOTS(KEY_SLOTS)) u_snis_checker (.*);
